[rtl/ncs_pkg.sv]
`default_nettype none

package ncs_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int TUNER_W = 33;
    localparam int RATE_W  = 26;
    localparam int NUM_W   = 5;
    localparam int QRY_W   = 33;
    localparam int CTR_W   = 35;
    localparam int SPC_W   = 25;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 33;

    localparam int IN_W = ((QRY_W + 7) / 8) * 8;

    localparam logic [RATE_W-1:0] RATE_RST = 26'd2048000;
    localparam logic [NUM_W-1:0]  NUM_RST  = 5'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TUNER = 2'd0,
        REG_RATE  = 2'd1,
        REG_NUM   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_DIV,
        ST_BUILD,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              done;
        logic [SPC_W-1:0]  spacing;
    } t_setup_st;

endpackage

`default_nettype wire

[rtl/nearest_channel_select_unit.sv]
// A query passes the query register, the leaf register, each level of the compare tree over all
// channel centres and the output register; one query per cycle is taken unless the output stalls.
// After reset, and after every configuration write, the input is not ready while the bit-serial
// spacing divider runs and then while the centre table of N+1 entries is built (N = channels).
// Reset is synchronous and active low; it restores the default configuration.
`default_nettype none

module nearest_channel_select_unit #(
    parameter int MAX_CHANNELS = ncs_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1),
    localparam int OUT_W = ((CH_W + ncs_pkg::CTR_W + ncs_pkg::SPC_W + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ncs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields from bit 0: query_freq.
    input  wire logic [ncs_pkg::IN_W-1:0]        i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // Fields from bit 0: channel, chan_center, chan_spacing.
    output logic [OUT_W-1:0]                     o_m_axis_tdata,
    // Fields from bit 0: found.
    output logic                                 o_m_axis_tuser
);
    import ncs_pkg::*;

    t_setup_st               w_st;
    logic [CH_W-1:0]         w_neff;
    logic [RATE_W-1:0]       w_rate;
    logic signed [CTR_W-1:0] w_centre_tab [MAX_CHANNELS+1];
    logic                    w_srch_ready;
    logic                    w_found;
    logic [CH_W-1:0]         w_channel;
    logic signed [CTR_W-1:0] w_centre;
    logic [SPC_W-1:0]        w_spacing;

    ncs_setup #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .o_st      (w_st),
        .o_neff    (w_neff),
        .o_rate    (w_rate),
        .o_centre  (w_centre_tab)
    );

    ncs_search #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid && w_st.done),
        .o_ready  (w_srch_ready),
        .i_query  (i_s_axis_tdata[QRY_W-1:0]),
        .i_neff   (w_neff),
        .i_rate   (w_rate),
        .i_centre (w_centre_tab),
        .i_spacing(w_st.spacing),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_found  (w_found),
        .o_channel(w_channel),
        .o_centre (w_centre),
        .o_spacing(w_spacing)
    );

    assign o_s_axis_tready = w_srch_ready && w_st.done;
    assign o_m_axis_tuser  = w_found;
    assign o_m_axis_tdata  = OUT_W'({w_spacing, w_centre, w_channel});

endmodule

`default_nettype wire

[rtl/ncs_setup.sv]
`default_nettype none

module ncs_setup #(
    parameter int MAX_CHANNELS = ncs_pkg::MAX_CHANNELS_DEF,
    localparam int NW = $clog2(MAX_CHANNELS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ncs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ncs_pkg::t_setup_st                     o_st,
    output logic [NW-1:0]                          o_neff,
    output logic [ncs_pkg::RATE_W-1:0]             o_rate,
    output logic signed [ncs_pkg::CTR_W-1:0]       o_centre [MAX_CHANNELS+1]
);
    import ncs_pkg::*;

    localparam int CNT_W = (NW > 5) ? NW : 5;
    localparam int BIT_W = $clog2(RATE_W);

    typedef struct packed {
        logic div_en;
        logic build_en;
        logic done;
    } t_ctl;

    logic [TUNER_W-1:0] r_tuner;
    logic [RATE_W-1:0]  r_rate;
    logic [NUM_W-1:0]   r_num;

    t_state             r_state, n_state;
    t_ctl               w_ctl;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [NW-1:0]      r_rem, n_rem;
    logic [RATE_W-1:0]  r_quo, n_quo;
    logic [RATE_W-1:0]  r_acc, n_acc;
    logic signed [CTR_W-1:0] r_centre [MAX_CHANNELS+1];

    logic [NW-1:0]      w_neff;
    logic [NW-1:0]      w_half;
    logic [BIT_W-1:0]   w_bit_idx;
    logic [NW:0]        w_trial;
    logic               w_div_last;
    logic               w_build_last;
    logic signed [CTR_W-1:0] w_tuner, w_hrate, w_acc, w_centre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuner <= '0;
            r_rate  <= RATE_RST;
            r_num   <= NUM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_TUNER: r_tuner <= i_cfg_data[TUNER_W-1:0];
                REG_RATE:  r_rate  <= i_cfg_data[RATE_W-1:0];
                REG_NUM:   r_num   <= i_cfg_data[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_num < NUM_W'(2)) begin
            w_neff = NW'(2);
        end else if (int'(r_num) > MAX_CHANNELS) begin
            w_neff = NW'(MAX_CHANNELS);
        end else begin
            w_neff = NW'(r_num);
        end
        w_neff = w_neff & {{(NW-1){1'b1}}, 1'b0};
        w_half = w_neff >> 1;
    end

    assign w_div_last   = (r_cnt == CNT_W'(RATE_W - 1));
    assign w_build_last = (r_cnt == CNT_W'(w_neff));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_DIV:   if (w_div_last) n_state = ST_BUILD;
            ST_BUILD: if (w_build_last) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_DIV;
        endcase
        if (i_cfg_we) begin
            n_state = ST_DIV;
        end
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            ST_DIV:   w_ctl.div_en = 1'b1;
            ST_BUILD: w_ctl.build_en = 1'b1;
            ST_RUN:   w_ctl.done = 1'b1;
            default:  w_ctl = '0;
        endcase
    end

    // Restoring division of the sample rate by the channel count, one bit per cycle.
    assign w_bit_idx = BIT_W'(RATE_W - 1) - r_cnt[BIT_W-1:0];
    assign w_trial   = {((r_cnt == '0) ? NW'(0) : r_rem), r_rate[w_bit_idx]};

    // Channel centres are built one entry per cycle with a running offset.
    assign w_tuner = $signed({2'b00, r_tuner});
    assign w_hrate = $signed({{(CTR_W-RATE_W+1){1'b0}}, r_rate[RATE_W-1:1]});
    assign w_acc   = $signed({{(CTR_W-RATE_W){1'b0}}, r_acc});

    always_comb begin
        if (r_cnt < CNT_W'(w_half)) begin
            w_centre = w_tuner + w_acc;
        end else if (r_cnt < CNT_W'(w_neff)) begin
            w_centre = w_tuner - w_hrate + w_acc;
        end else begin
            w_centre = w_tuner + w_hrate;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_acc = r_acc;
        if (w_ctl.div_en) begin
            n_cnt = w_div_last ? '0 : r_cnt + CNT_W'(1);
            n_acc = '0;
            if (w_trial >= {1'b0, w_neff}) begin
                n_rem = NW'(w_trial - {1'b0, w_neff});
                n_quo = {r_quo[RATE_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[NW-1:0];
                n_quo = {r_quo[RATE_W-2:0], 1'b0};
            end
        end else if (w_ctl.build_en) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt + CNT_W'(1) == CNT_W'(w_half)) begin
                n_acc = '0;
            end else begin
                n_acc = r_acc + RATE_W'(r_quo[SPC_W-1:0]);
            end
        end
        if (i_cfg_we) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DIV;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_acc <= n_acc;
        if (w_ctl.build_en) begin
            r_centre[r_cnt[NW-1:0]] <= w_centre;
        end
    end

    assign o_st.done    = w_ctl.done;
    assign o_st.spacing = r_quo[SPC_W-1:0];
    assign o_neff       = w_neff;
    assign o_rate       = r_rate;
    assign o_centre     = r_centre;

endmodule

`default_nettype wire

[rtl/ncs_search.sv]
`default_nettype none

module ncs_search #(
    parameter int MAX_CHANNELS = ncs_pkg::MAX_CHANNELS_DEF,
    localparam int NW = $clog2(MAX_CHANNELS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ncs_pkg::QRY_W-1:0]         i_query,
    input  wire logic [NW-1:0]                     i_neff,
    input  wire logic [ncs_pkg::RATE_W-1:0]        i_rate,
    input  wire logic signed [ncs_pkg::CTR_W-1:0]  i_centre [MAX_CHANNELS+1],
    input  wire logic [ncs_pkg::SPC_W-1:0]         i_spacing,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_found,
    output logic [NW-1:0]                          o_channel,
    output logic signed [ncs_pkg::CTR_W-1:0]       o_centre,
    output logic [ncs_pkg::SPC_W-1:0]              o_spacing
);
    import ncs_pkg::*;

    localparam int LVL   = $clog2(MAX_CHANNELS + 1);
    localparam int LEAF  = 1 << LVL;
    localparam int NODES = 2 * LEAF - 1;

    typedef struct packed {
        logic              ok;
        logic [RATE_W-1:0] gap;
        logic [NW-1:0]     idx;
    } t_cand;

    logic               w_en;
    logic [QRY_W-1:0]   r_query;
    logic [LVL+1:0]     r_vld;
    t_cand              r_node [NODES];
    t_cand              n_node [NODES];
    t_cand              w_leaf [LEAF];

    logic                    r_ovld;
    logic                    r_found;
    logic [NW-1:0]           r_channel;
    logic signed [CTR_W-1:0] r_centre;
    logic [SPC_W-1:0]        r_spacing;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    for (genvar gi = 0; gi < LEAF; gi++) begin : g_leaf
        if (gi <= MAX_CHANNELS) begin : g_used
            logic signed [CTR_W:0] w_diff;
            logic [CTR_W:0]        w_mag;
            assign w_diff = $signed({3'b000, r_query})
                          - $signed({i_centre[gi][CTR_W-1], i_centre[gi]});
            assign w_mag  = w_diff[CTR_W] ? (CTR_W+1)'(-w_diff) : w_diff;
            assign w_leaf[gi].ok   = (NW'(gi) <= i_neff)
                                  && (w_mag < {{(CTR_W+1-RATE_W){1'b0}}, i_rate});
            assign w_leaf[gi].gap  = w_mag[RATE_W-1:0];
            assign w_leaf[gi].idx  = NW'(gi);
        end else begin : g_pad
            assign w_leaf[gi] = '0;
        end
    end

    // Each tree node keeps the closer child; on equal distance the lower index wins.
    always_comb begin
        for (int j = 0; j < LEAF - 1; j++) begin
            if (r_node[2*j+1].ok
                && (!r_node[2*j+2].ok || r_node[2*j+1].gap <= r_node[2*j+2].gap)) begin
                n_node[j] = r_node[2*j+1];
            end else begin
                n_node[j] = r_node[2*j+2];
            end
        end
        for (int k = 0; k < LEAF; k++) begin
            n_node[LEAF-1+k] = w_leaf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[LVL:0], i_valid};
            r_ovld <= r_vld[LVL+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (i_valid) begin
                r_query <= i_query;
            end
            r_node    <= n_node;
            r_found   <= r_node[0].ok;
            r_channel <= r_node[0].ok ? r_node[0].idx : '0;
            r_centre  <= r_node[0].ok ? i_centre[r_node[0].idx] : '0;
            r_spacing <= i_spacing;
        end
    end

    assign o_valid   = r_ovld;
    assign o_found   = r_found;
    assign o_channel = r_channel;
    assign o_centre  = r_centre;
    assign o_spacing = r_spacing;

endmodule

`default_nettype wire

[rtl/ncs_checker.sv]
`default_nettype none

module ncs_checker #(
    parameter int MAX_CHANNELS = ncs_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1),
    localparam int OUT_W = ((CH_W + ncs_pkg::CTR_W + ncs_pkg::SPC_W + 7) / 8) * 8
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_we,
    input wire logic [ncs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input wire logic [ncs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [ncs_pkg::IN_W-1:0]        i_s_axis_tdata,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [OUT_W-1:0]                o_m_axis_tdata,
    input wire logic                            o_m_axis_tuser
);
    import ncs_pkg::*;

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[CH_W+CTR_W-1:0] == '0)
        else $error("Result without a channel carries a nonzero channel or centre.");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            int'(o_m_axis_tdata[CH_W-1:0]) <= MAX_CHANNELS)
        else $error("Reported channel lies beyond the channel table.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Stalled result transfer changed.");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("Block active right after reset.");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_axis_tready)
        else $error("Input accepted before the channel table was rebuilt.");

endmodule

bind nearest_channel_select_unit ncs_checker #(
    .MAX_CHANNELS(MAX_CHANNELS)
) u_ncs_checker (.*);

`default_nettype wire

[tb/sv/nearest_channel_select_checker.sv]
`timescale 1ns / 100ps

module nearest_channel_select_checker
    import ncs_pkg::*;
(
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ncs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_s_axis_tvalid,
    input  wire logic                            i_s_axis_tready,
    // Fields from bit 0: query_freq.
    input  wire logic [ncs_pkg::IN_W-1:0]        i_s_axis_tdata,
    input  wire logic                            i_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // Fields from bit 0: channel, chan_center, chan_spacing.
    input  wire logic [((($clog2(ncs_pkg::MAX_CHANNELS_DEF + 1)) + ncs_pkg::CTR_W
                        + ncs_pkg::SPC_W + 7) / 8) * 8 - 1:0] i_m_axis_tdata,
    // Fields from bit 0: found.
    input  wire logic                            i_m_axis_tuser,
    output int                                   o_fail_count,
    output int                                   o_open_count
);

    localparam int CH_W = $clog2(MAX_CHANNELS_DEF + 1);

    typedef struct packed {
        logic                    found;
        logic [CH_W-1:0]         channel;
        logic signed [CTR_W-1:0] center;
        logic [SPC_W-1:0]        spacing;
    } t_pick;

    logic [TUNER_W-1:0] tuner_hz;
    logic [RATE_W-1:0]  rate_hz;
    logic [NUM_W-1:0]   chan_count;
    t_pick              pending_picks[$];

    function automatic t_pick nearest_channel(input logic [QRY_W-1:0] query);
        t_pick  pick;
        longint n;
        longint spacing;
        longint half_rate;
        longint centre;
        longint gap;
        longint best;
        n = chan_count;
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_CHANNELS_DEF) begin
            n = MAX_CHANNELS_DEF;
        end
        n = n - (n % 2);
        spacing = longint'(rate_hz) / n;
        half_rate = longint'(rate_hz) / 2;
        best = longint'(rate_hz);
        pick = '0;
        pick.spacing = spacing[SPC_W-1:0];
        for (longint i = 0; i <= n; i++) begin
            if (i == n) begin
                centre = longint'(tuner_hz) + half_rate;
            end else if (i < n / 2) begin
                centre = longint'(tuner_hz) + spacing * i;
            end else begin
                centre = longint'(tuner_hz) - half_rate + spacing * (i - n / 2);
            end
            gap = longint'(query) - centre;
            if (gap < 0) begin
                gap = -gap;
            end
            if (gap < best) begin
                best = gap;
                pick.found = 1'b1;
                pick.channel = i[CH_W-1:0];
                pick.center = centre[CTR_W-1:0];
            end
        end
        return pick;
    endfunction

    always @(posedge i_clk) begin
        t_pick                   want;
        logic [CH_W-1:0]         got_channel;
        logic signed [CTR_W-1:0] got_center;
        logic [SPC_W-1:0]        got_spacing;
        if (!i_rst_n) begin
            tuner_hz = '0;
            rate_hz = RATE_RST;
            chan_count = NUM_RST;
            pending_picks.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_channel = i_m_axis_tdata[CH_W-1:0];
                got_center = i_m_axis_tdata[CH_W +: CTR_W];
                got_spacing = i_m_axis_tdata[CH_W + CTR_W +: SPC_W];
                if (pending_picks.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result transfer with none expected, got found %0d",
                             $time, i_m_axis_tuser,
                             " channel %0d center %0d spacing %0d",
                             got_channel, got_center, got_spacing);
                end else begin
                    want = pending_picks.pop_front();
                    if (i_m_axis_tuser !== want.found) begin
                        o_fail_count++;
                        $display("%0t: found expected %0d, got %0d",
                                 $time, want.found, i_m_axis_tuser);
                    end
                    if (got_channel !== want.channel) begin
                        o_fail_count++;
                        $display("%0t: channel expected %0d, got %0d",
                                 $time, want.channel, got_channel);
                    end
                    if (got_center !== want.center) begin
                        o_fail_count++;
                        $display("%0t: chan_center expected %0d, got %0d",
                                 $time, want.center, got_center);
                    end
                    if (got_spacing !== want.spacing) begin
                        o_fail_count++;
                        $display("%0t: chan_spacing expected %0d, got %0d",
                                 $time, want.spacing, got_spacing);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pending_picks.insert(pending_picks.size(),
                                     nearest_channel(i_s_axis_tdata[QRY_W-1:0]));
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TUNER: begin
                        tuner_hz = i_cfg_data[TUNER_W-1:0];
                    end
                    REG_RATE: begin
                        rate_hz = i_cfg_data[RATE_W-1:0];
                    end
                    REG_NUM: begin
                        chan_count = i_cfg_data[NUM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_open_count = pending_picks.size();
    end

endmodule

[tb/sv/nearest_channel_select_unit_test.sv]
`timescale 1ns / 100ps

module nearest_channel_select_unit_test;

    import ncs_pkg::*;

    localparam int CH_W  = $clog2(MAX_CHANNELS_DEF + 1);
    localparam int OUT_W = ((CH_W + CTR_W + SPC_W + 7) / 8) * 8;
    localparam longint QUERY_MAX = 64'h1_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    int                    fail_count;
    int                    open_count;

    logic   steady = 1'b0;
    logic   hold_armed = 1'b0;
    int     hold_left = 0;
    longint cur_tuner = 0;
    longint cur_rate = 2048000;
    longint cur_n = 2;

    nearest_channel_select_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    nearest_channel_select_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_open_count    (open_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("nearest_channel_select_unit_test: done, errors");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed) begin
                hold_left = 300;
                hold_armed = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = steady || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] v);
        longint n;
        cfg_we = 1'b1;
        cfg_addr = r;
        cfg_data = v;
        case (r)
            REG_TUNER: begin
                cur_tuner = v[TUNER_W-1:0];
            end
            REG_RATE: begin
                cur_rate = v[RATE_W-1:0];
            end
            default: begin
                n = v[NUM_W-1:0];
                if (n < 2) begin
                    n = 2;
                end
                if (n > MAX_CHANNELS_DEF) begin
                    n = MAX_CHANNELS_DEF;
                end
                cur_n = n - (n % 2);
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_query(input longint q);
        while (!steady && $urandom_range(99) < 33) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = IN_W'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = IN_W'(q[QRY_W-1:0]);
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (open_count != 0) begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);
    endtask

    function automatic longint pick_query();
        longint q;
        longint w;
        longint sp;
        case ($urandom_range(9))
            0, 1: begin
                q = {1'($urandom_range(1)), $urandom()};
            end
            2, 3: begin
                sp = cur_rate / cur_n;
                q = longint'($urandom_range(0, 4)) - 2 + sp * $urandom_range(0, cur_n);
                if ($urandom_range(1)) begin
                    q = q + cur_tuner - cur_rate / 2;
                end else begin
                    q = q + cur_tuner;
                end
            end
            default: begin
                w = cur_rate + cur_rate / 4 + 16;
                q = cur_tuner + longint'($urandom_range(0, 2 * w)) - w;
            end
        endcase
        if (q < 0) begin
            q = 0;
        end
        if (q > QUERY_MAX) begin
            q = QUERY_MAX;
        end
        return q;
    endfunction

    task automatic shuffle_config();
        logic [2:0] which;
        logic [RATE_W-1:0] rate;
        which = 3'($urandom_range(1, 7));
        if (which[0]) begin
            case ($urandom_range(3))
                0: write_reg(REG_TUNER, {1'($urandom_range(1)), $urandom()});
                1: write_reg(REG_TUNER, 33'($urandom_range(0, 100000)));
                2: write_reg(REG_TUNER, 33'h1_FFFF_FFFF - 33'($urandom_range(0, 50000000)));
                default: write_reg(REG_TUNER, 33'd100000000 + 33'($urandom));
            endcase
        end
        if (which[1]) begin
            case ($urandom_range(3))
                0: rate = 26'($urandom_range(1, 5000));
                1: rate = 26'($urandom);
                2: rate = 26'h3FF_FFFF;
                default: rate = 26'($urandom_range(1000000, 20000000));
            endcase
            write_reg(REG_RATE, {7'($urandom), rate});
        end
        if (which[2]) begin
            if ($urandom_range(3) == 0) begin
                write_reg(REG_NUM, {28'($urandom), 5'($urandom_range(0, 31))});
            end else begin
                write_reg(REG_NUM, {28'($urandom), 5'(2 * $urandom_range(1, 8))});
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_query(0);
        send_query(1024000);
        send_query(2047999);
        send_query(QUERY_MAX);
        drain();

        write_reg(REG_TUNER, 33'd990);
        write_reg(REG_RATE, 33'd2000);
        send_query(0);
        send_query(500);
        send_query(490);
        drain();

        write_reg(REG_TUNER, 33'd1000000000);
        write_reg(REG_RATE, 33'd2048000);
        write_reg(REG_NUM, 33'd8);
        send_query(1000000000);
        send_query(1001024000);
        send_query(998976000);
        send_query(1000128000);
        send_query(1003000000);
        send_query(1003072000);
        drain();

        write_reg(REG_TUNER, 33'h1_FFFF_FFFF);
        write_reg(REG_RATE, 33'h3FF_FFFF);
        write_reg(REG_NUM, 33'd16);
        send_query(QUERY_MAX);
        send_query(0);
        send_query(QUERY_MAX - 33554431);
        send_query(QUERY_MAX - 4194303);
        drain();

        write_reg(REG_TUNER, 33'd5000000);
        write_reg(REG_RATE, 33'd3000000);
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: write_reg(REG_NUM, 33'd0);
                1: write_reg(REG_NUM, 33'd1);
                2: write_reg(REG_NUM, 33'd3);
                3: write_reg(REG_NUM, 33'd17);
                default: write_reg(REG_NUM, 33'd31);
            endcase
            send_query(6000000);
            drain();
        end

        write_reg(REG_RATE, 33'd0);
        send_query(5000000);
        drain();

        for (int phase = 0; phase < 15; phase++) begin
            shuffle_config();
            steady = (phase == 3);
            if (phase == 6) begin
                hold_armed = 1'b1;
            end
            for (int k = 0; k < 95; k++) begin
                send_query(pick_query());
            end
            drain();
        end
        steady = 1'b0;

        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("nearest_channel_select_unit_test: done, clean");
        end else begin
            $display("nearest_channel_select_unit_test: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ncs_pkg.sv
rtl/ncs_setup.sv
rtl/ncs_search.sv
rtl/nearest_channel_select_unit.sv
rtl/ncs_checker.sv
tb/sv/nearest_channel_select_checker.sv
tb/sv/nearest_channel_select_unit_test.sv
